>>> rtl/retransmit_timeout_estimator_unit_assert.svh
// ----------------------------------------------------------------------------
// Retransmit timeout estimator assertion macros
// Clocked on clock and disabled in reset, as the checker ports name them.
// ----------------------------------------------------------------------------
`ifndef RETRANSMIT_TIMEOUT_ESTIMATOR_UNIT_ASSERT_SVH
`define RETRANSMIT_TIMEOUT_ESTIMATOR_UNIT_ASSERT_SVH

// Consequent checked in the same cycle as the antecedent.
`define RTEU_ASSERT_SAME(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define RTEU_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> rtl/rteu_pkg.sv
// ----------------------------------------------------------------------------
// rteu_pkg
// Widths, register indexes and reset values of the retransmit timeout
// estimator.
// ----------------------------------------------------------------------------
package rteu_pkg;

   localparam int MS_W      = 16;   // millisecond quantities
   localparam int ID_W      = 16;   // command id
   localparam int SENT_W    = 8;    // transmit count
   localparam int SHIFT_W   = 4;    // backoff shift count
   localparam int RTT_W     = 19;   // srtt / rttvar, 3 fraction bits

   localparam int REQ_DATA_W = 40;  // sample, id, times_sent
   localparam int RSP_DATA_W = 48;  // timeout, delay, average

   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 16;

   localparam int HISTORY_DEPTH_DEFAULT = 16;

   typedef logic [MS_W-1:0]  ms_type;
   typedef logic [RTT_W-1:0] rtt_type;

   // register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_MIN_RETRY  = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_MAX_RETRY  = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_MAX_SHIFTS = 2'd2;

   // command codes (the other code is a delay query)
   localparam logic CMD_ACK = 1'b0;

   // reset values
   localparam ms_type               MIN_RETRY_RESET  = 16'd150;
   localparam ms_type               MAX_RETRY_RESET  = 16'd2000;
   localparam logic [SHIFT_W-1:0]   MAX_SHIFTS_RESET = 4'd2;

endpackage

>>> rtl/rteu_ram.sv
// ----------------------------------------------------------------------------
// rteu_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module rteu_ram #(
   parameter int WIDTH = rteu_pkg::MS_W,
   parameter int DEPTH = rteu_pkg::HISTORY_DEPTH_DEFAULT
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];   // read-before-write
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/retransmit_timeout_estimator_unit.sv
// ----------------------------------------------------------------------------
// retransmit_timeout_estimator_unit
// Smoothed RTT / variance estimator with Karn's rule, clamped retransmit
// timeout, bounded exponential backoff and a latency history mean.
// ----------------------------------------------------------------------------
//
//   channel  dir  handshake             payload
//   req_     in   req_tvalid/tready     tdata: sample, id, times_sent; tuser: command
//   rsp_     out  rsp_tvalid/tready     tdata: timeout, delay, average latency
//   csr_     in   csr_wr_en (no wait)   csr_index, csr_wdata
//
// One item per cycle sustained while results are taken. Five register stages from
// the accepting edge to rsp_tvalid: input register, history RAM read, state update,
// timeout clamp and mean multiply, result register.
// Synchronous reset; history entries carry valid bits, so no clearing pass.
// A stalled result freezes the pipe; the input register still takes one more
// transfer while the result waits.
// ----------------------------------------------------------------------------
module retransmit_timeout_estimator_unit #(
   parameter int HISTORY_DEPTH = rteu_pkg::HISTORY_DEPTH_DEFAULT
) (
   input  logic                                 clock,
   input  logic                                 reset,

   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   // [15:0] sample_ms, [31:16] command_id, [39:32] times_sent
   input  logic [rteu_pkg::REQ_DATA_W-1:0]      req_tdata,
   // [0] command (0 = ack, 1 = query)
   input  logic                                 req_tuser,

   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   // [15:0] retry_timeout_ms, [31:16] retry_delay_ms, [47:32] average_latency_ms
   output logic [rteu_pkg::RSP_DATA_W-1:0]      rsp_tdata,

   input  logic                                 csr_wr_en,
   input  logic [rteu_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [rteu_pkg::CSR_DATA_W-1:0]      csr_wdata
);

   localparam int MS_W    = rteu_pkg::MS_W;
   localparam int ID_W    = rteu_pkg::ID_W;
   localparam int SENT_W  = rteu_pkg::SENT_W;
   localparam int SHIFT_W = rteu_pkg::SHIFT_W;
   localparam int RTT_W   = rteu_pkg::RTT_W;

   localparam int SLOT_W = $clog2(HISTORY_DEPTH);
   localparam int SUM_W  = MS_W + SLOT_W;

   // Division by the history depth as a multiply by a rounded-up reciprocal;
   // exact for every numerator of the given width.
   localparam int ID_SH      = ID_W + SLOT_W;
   localparam int ID_PROD_W  = 2 * ID_W + 1;
   localparam int AVG_SH     = SUM_W + SLOT_W;
   localparam int AVG_PROD_W = 2 * SUM_W + 1;
   localparam logic [63:0] DEPTH64   = 64'(HISTORY_DEPTH);
   localparam logic [63:0] ID_MUL64  = ((64'd1 << ID_SH) + DEPTH64 - 64'd1) / DEPTH64;
   localparam logic [63:0] AVG_MUL64 = ((64'd1 << AVG_SH) + DEPTH64 - 64'd1) / DEPTH64;
   localparam logic [ID_W:0]   ID_MUL   = ID_MUL64[ID_W:0];
   localparam logic [SUM_W:0]  AVG_MUL  = AVG_MUL64[SUM_W:0];
   localparam logic [ID_W-1:0] DEPTH_ID = DEPTH64[ID_W-1:0];

   localparam int DLY_W = MS_W + (1 << SHIFT_W) - 1;   // widest backed-off delay

   // ---------------------------------------------------------------- config
   rteu_pkg::ms_type     min_retry_ff;
   rteu_pkg::ms_type     max_retry_ff;
   logic [SHIFT_W-1:0]   max_shifts_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         min_retry_ff  <= rteu_pkg::MIN_RETRY_RESET;
         max_retry_ff  <= rteu_pkg::MAX_RETRY_RESET;
         max_shifts_ff <= rteu_pkg::MAX_SHIFTS_RESET;
      end else if (csr_wr_en) begin
         case (csr_index)
            rteu_pkg::CSR_MIN_RETRY:  min_retry_ff  <= csr_wdata[MS_W-1:0];
            rteu_pkg::CSR_MAX_RETRY:  max_retry_ff  <= csr_wdata[MS_W-1:0];
            rteu_pkg::CSR_MAX_SHIFTS: max_shifts_ff <= csr_wdata[SHIFT_W-1:0];
            default: ;
         endcase
      end
   end

   // -------------------------------------------------------------- pipe flow
   // Pipe moves together when the result register is free or drained; only the input stage can fill in a stall.
   logic advance;
   logic req_xfer;
   logic s1_valid_ff, s2_valid_ff, s3_valid_ff, s4_valid_ff, rsp_valid_ff;
   logic s1_valid_in;

   assign advance    = !rsp_valid_ff || rsp_tready;
   assign req_tready = advance || !s1_valid_ff;   // empty input stage fills during a stall
   assign req_xfer   = req_tvalid && req_tready;
   assign s1_valid_in = req_xfer || (s1_valid_ff && !advance);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         s4_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         if (advance) begin
            s2_valid_ff  <= s1_valid_ff;
            s3_valid_ff  <= s2_valid_ff;
            s4_valid_ff  <= s3_valid_ff;
            rsp_valid_ff <= s4_valid_ff;
         end
      end
   end

   // ------------------------------------------------------- stage 1: input
   logic                   s1_cmd_ff;
   rteu_pkg::ms_type       s1_sample_ff;
   logic [ID_W-1:0]        s1_id_ff;
   logic [SENT_W-1:0]      s1_sent_ff;
   logic [ID_PROD_W-1:0]   s1_id_prod_ff;
   logic [ID_PROD_W-1:0]   s1_id_prod_in;

   assign s1_id_prod_in = ID_PROD_W'(req_tdata[2*MS_W-1:MS_W]) * ID_PROD_W'(ID_MUL);

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         s1_cmd_ff     <= req_tuser;
         s1_sample_ff  <= req_tdata[MS_W-1:0];
         s1_id_ff      <= req_tdata[2*MS_W-1:MS_W];
         s1_sent_ff    <= req_tdata[2*MS_W+SENT_W-1:2*MS_W];
         s1_id_prod_ff <= s1_id_prod_in;
      end
   end

   // slot = id mod depth
   logic [ID_PROD_W-1:0] id_quot_full;
   logic [ID_W-1:0]      id_quot;
   logic [ID_W-1:0]      id_quot_x_d;
   logic [ID_W-1:0]      id_rem;
   logic [SLOT_W-1:0]    s1_slot;

   assign id_quot_full = s1_id_prod_ff >> ID_SH;
   assign id_quot      = id_quot_full[ID_W-1:0];
   assign id_quot_x_d  = id_quot * DEPTH_ID;
   assign id_rem       = s1_id_ff - id_quot_x_d;
   assign s1_slot      = id_rem[SLOT_W-1:0];

   // backoff shifts = min(times_sent - 1, max), times_sent zero counts as one
   logic [SENT_W-1:0]  sent_m1;
   logic [SHIFT_W-1:0] s1_shifts;
   logic               s1_ack;
   logic               s1_timed;

   assign sent_m1   = (s1_sent_ff == '0) ? '0 : s1_sent_ff - SENT_W'(1);
   assign s1_shifts = (sent_m1 > SENT_W'(max_shifts_ff)) ? max_shifts_ff
                                                          : sent_m1[SHIFT_W-1:0];
   assign s1_ack    = (s1_cmd_ff == rteu_pkg::CMD_ACK);
   assign s1_timed  = s1_ack && (s1_sent_ff <= SENT_W'(1));   // Karn's rule

   // --------------------------------------------- stage 2: history and RTT
   logic                   s2_ack_ff, s2_timed_ff;
   rteu_pkg::ms_type       s2_sample_ff;
   logic [SLOT_W-1:0]      s2_slot_ff;
   logic [SHIFT_W-1:0]     s2_shifts_ff;
   logic                   s2_hit_ff;       // older item wrote this slot on the read edge
   rteu_pkg::ms_type       s2_fwd_ff;
   logic                   s2_old_vld_ff;

   logic                   hist_wr_en;
   logic                   hist_rd_en;
   rteu_pkg::ms_type       hist_rd_data;
   logic [HISTORY_DEPTH-1:0] hist_vld_ff;

   assign hist_wr_en = advance && s2_valid_ff && s2_ack_ff;
   assign hist_rd_en = advance && s1_valid_ff;

   rteu_ram #(
      .WIDTH (MS_W),
      .DEPTH (HISTORY_DEPTH)
   ) u_hist_ram (
      .clock   (clock),
      .wr_en   (hist_wr_en),
      .wr_addr (s2_slot_ff),
      .wr_data (s2_sample_ff),
      .rd_en   (hist_rd_en),
      .rd_addr (s1_slot),
      .rd_data (hist_rd_data)
   );

   always_ff @(posedge clock) begin
      if (advance) begin
         s2_ack_ff     <= s1_ack;
         s2_timed_ff   <= s1_timed;
         s2_sample_ff  <= s1_sample_ff;
         s2_slot_ff    <= s1_slot;
         s2_shifts_ff  <= s1_shifts;
         s2_hit_ff     <= hist_wr_en && (s2_slot_ff == s1_slot);
         s2_fwd_ff     <= s2_sample_ff;
         s2_old_vld_ff <= hist_vld_ff[s1_slot];
      end
   end

   // entry being replaced; an entry never written reads as zero
   rteu_pkg::ms_type hist_old;
   logic [SUM_W-1:0] sum_ff;
   logic [SUM_W-1:0] sum_in;

   assign hist_old = s2_hit_ff     ? s2_fwd_ff    :
                     s2_old_vld_ff ? hist_rd_data : '0;
   assign sum_in   = sum_ff - SUM_W'(hist_old) + SUM_W'(s2_sample_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         hist_vld_ff <= '0;
         sum_ff      <= '0;
      end else if (hist_wr_en) begin
         hist_vld_ff[s2_slot_ff] <= 1'b1;
         sum_ff                  <= sum_in;
      end
   end

   // Jacobson/Karels update, 3 fraction bits, truncating
   rteu_pkg::rtt_type srtt_ff, rttvar_ff;
   rteu_pkg::rtt_type srtt_in, rttvar_in;
   logic              have_sample_ff;
   rteu_pkg::rtt_type sample_x8;
   rteu_pkg::rtt_type rtt_dev;
   logic [RTT_W+2:0]  var_acc;    // 3*rttvar + dev
   logic [RTT_W+3:0]  srtt_acc;   // 7*srtt + sample*8
   logic              rtt_update;

   assign sample_x8 = {s2_sample_ff, 3'b000};
   assign rtt_dev   = (srtt_ff >= sample_x8) ? srtt_ff - sample_x8 : sample_x8 - srtt_ff;
   assign var_acc   = (RTT_W+3)'(rttvar_ff) + (RTT_W+3)'({rttvar_ff, 1'b0})
                    + (RTT_W+3)'(rtt_dev);
   assign srtt_acc  = (RTT_W+4)'({srtt_ff, 3'b000}) - (RTT_W+4)'(srtt_ff)
                    + (RTT_W+4)'(sample_x8);

   always_comb begin
      if (!have_sample_ff) begin
         // first sample seeds srtt = s, rttvar = s/2
         srtt_in   = sample_x8;
         rttvar_in = RTT_W'({s2_sample_ff, 2'b00});
      end else begin
         srtt_in   = srtt_acc[RTT_W+2:3];
         rttvar_in = var_acc[RTT_W+1:2];
      end
   end

   assign rtt_update = advance && s2_valid_ff && s2_timed_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         srtt_ff        <= '0;
         rttvar_ff      <= '0;
         have_sample_ff <= 1'b0;
      end else if (rtt_update) begin
         srtt_ff        <= srtt_in;
         rttvar_ff      <= rttvar_in;
         have_sample_ff <= 1'b1;
      end
   end

   // ------------------------------------- stage 3: timeout clamp, mean mult
   logic                  s3_timed_ff;
   logic [SHIFT_W-1:0]    s3_shifts_ff;

   always_ff @(posedge clock) begin
      if (advance) begin
         s3_timed_ff  <= s2_timed_ff;
         s3_shifts_ff <= s2_shifts_ff;
      end
   end

   logic [RTT_W+2:0]  tmo_acc;     // srtt + 4*rttvar
   logic [RTT_W-1:0]  tmo_ms;
   logic [RTT_W-1:0]  tmo_floor;
   rteu_pkg::ms_type  base_ff;
   rteu_pkg::ms_type  base_in;

   assign tmo_acc   = (RTT_W+3)'(srtt_ff) + (RTT_W+3)'({rttvar_ff, 2'b00});
   assign tmo_ms    = tmo_acc[RTT_W+2:3];
   assign tmo_floor = (tmo_ms < RTT_W'(min_retry_ff)) ? RTT_W'(min_retry_ff) : tmo_ms;
   // ceiling wins over floor
   assign base_in   = (tmo_floor > RTT_W'(max_retry_ff)) ? max_retry_ff
                                                         : tmo_floor[MS_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff <= rteu_pkg::MAX_RETRY_RESET;
      end else if (advance && s3_valid_ff && s3_timed_ff) begin
         base_ff <= base_in;
      end
   end

   logic [AVG_PROD_W-1:0] avg_prod_in;
   logic [AVG_PROD_W-1:0] s4_avg_prod_ff;
   logic [SHIFT_W-1:0]    s4_shifts_ff;

   assign avg_prod_in = AVG_PROD_W'(sum_ff) * AVG_PROD_W'(AVG_MUL);

   always_ff @(posedge clock) begin
      if (advance) begin
         s4_avg_prod_ff <= avg_prod_in;
         s4_shifts_ff   <= s3_shifts_ff;
      end
   end

   // ------------------------------------------- stage 4: backoff and result
   logic [DLY_W-1:0]      delay_full;
   rteu_pkg::ms_type      delay_ms;
   logic [AVG_PROD_W-1:0] avg_full;
   rteu_pkg::ms_type      avg_ms;
   logic [rteu_pkg::RSP_DATA_W-1:0] rsp_data_ff;

   assign delay_full = DLY_W'(base_ff) << s4_shifts_ff;
   assign delay_ms   = (delay_full > DLY_W'(max_retry_ff)) ? max_retry_ff
                                                           : delay_full[MS_W-1:0];
   assign avg_full   = s4_avg_prod_ff >> AVG_SH;
   assign avg_ms     = avg_full[MS_W-1:0];

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_data_ff <= {avg_ms, delay_ms, base_ff};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

>>> rtl/rteu_checker.sv
// ----------------------------------------------------------------------------
// rteu_checker
// Port-level checks of the retransmit timeout estimator, bound to the top.
// ----------------------------------------------------------------------------
`include "retransmit_timeout_estimator_unit_assert.svh"

module rteu_checker (
   input logic                               clock,
   input logic                               reset,
   input logic                               req_tvalid,
   input logic                               req_tready,
   input logic                               rsp_tvalid,
   input logic                               rsp_tready,
   input logic [rteu_pkg::RSP_DATA_W-1:0]    rsp_tdata
);

   // stalled result holds
   `RTEU_ASSERT_NEXT(a_rsp_hold, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata), "rsp changed while stalled")

   // pipe comes out of reset empty
   `RTEU_ASSERT_SAME(a_rsp_empty_after_reset, $past(reset), !rsp_tvalid, "rsp valid right after reset")

   // empty result register never blocks the input side
   `RTEU_ASSERT_SAME(a_ready_when_empty, !rsp_tvalid, req_tready, "req blocked with empty result")

   // during a stall only the input register fills, then input backs up
   `RTEU_ASSERT_NEXT(a_one_transfer_in_stall, rsp_tvalid && !rsp_tready && req_tvalid && req_tready, rsp_tready || !req_tready, "second transfer taken during stall")

endmodule

bind retransmit_timeout_estimator_unit rteu_checker u_rteu_checker (.*);

>>> dv/tb.sv
// ----------------------------------------------------------------------------
// tb - retransmit timeout estimator testbench
// Drives ack and query transfers into retransmit_timeout_estimator_unit,
// tracks smoothed RTT, variance, clamped timeout, backoff and history mean in
// a cycle-free model of its own, and checks every result transfer in order.
// Directed cases come first, then random traffic over several register
// settings and idle patterns, with one long result stall to fill the pipe.
// ----------------------------------------------------------------------------
module tb;

   localparam int     MS_W        = rteu_pkg::MS_W;
   localparam int     ID_W        = rteu_pkg::ID_W;
   localparam int     SENT_W      = rteu_pkg::SENT_W;
   localparam int     SHIFT_W     = rteu_pkg::SHIFT_W;
   localparam int     RTT_W       = rteu_pkg::RTT_W;
   localparam int     REQ_DATA_W  = rteu_pkg::REQ_DATA_W;
   localparam int     RSP_DATA_W  = rteu_pkg::RSP_DATA_W;
   localparam int     CSR_INDEX_W = rteu_pkg::CSR_INDEX_W;
   localparam int     CSR_DATA_W  = rteu_pkg::CSR_DATA_W;

   localparam int     HALF_PERIOD     = 10;
   localparam int     RESET_CYCLES    = 9;
   // five pipe stages, with margin
   localparam int     PIPE_SETTLE     = 12;
   // hang guard limit, in simulation time
   localparam longint RUN_LIMIT       = 64'd8_000_000;
   localparam int     HIST_DEPTH      = rteu_pkg::HISTORY_DEPTH_DEFAULT;
   localparam int     RANDOM_PHASES   = 6;
   localparam int     ITEMS_PER_PHASE = 82;
   localparam int     MAX_REPORTS     = 10;
   localparam int     LONG_HOLD       = 400;

   // the non-ack command code; the package names only the ack
   localparam logic                   CMD_QUERY = ~rteu_pkg::CMD_ACK;
   // index with no register behind it; writes must be ignored
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE = 2'd3;

   typedef struct packed {
      logic              command;
      rteu_pkg::ms_type  sample_ms;
      logic [ID_W-1:0]   command_id;
      logic [SENT_W-1:0] times_sent;
   } rto_request_type;

   typedef struct packed {
      rteu_pkg::ms_type timeout_ms;
      rteu_pkg::ms_type delay_ms;
      rteu_pkg::ms_type average_ms;
   } rto_result_type;

   // ------------------------------------------------------------------------
   // DUT signals, all driven ones known from time zero
   // ------------------------------------------------------------------------
   logic                   clock      = 1'b0;
   logic                   reset      = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_DATA_W-1:0]  req_tdata  = '0;
   logic                   req_tuser  = 1'b0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0]  rsp_tdata;
   logic                   csr_wr_en  = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index  = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata  = '0;

   always #HALF_PERIOD clock = ~clock;

   retransmit_timeout_estimator_unit #(
      .HISTORY_DEPTH (HIST_DEPTH)
   ) u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   // ------------------------------------------------------------------------
   // Estimator state mirror: registers as last written, RTT estimate with
   // 3 fraction bits, base timeout and the latency history with its sum.
   // ------------------------------------------------------------------------
   rteu_pkg::ms_type   cfg_min_ms     = rteu_pkg::MIN_RETRY_RESET;
   rteu_pkg::ms_type   cfg_max_ms     = rteu_pkg::MAX_RETRY_RESET;
   logic [SHIFT_W-1:0] cfg_max_shifts = rteu_pkg::MAX_SHIFTS_RESET;

   rteu_pkg::rtt_type  est_srtt    = '0;
   rteu_pkg::rtt_type  est_rttvar  = '0;
   logic               est_seeded  = 1'b0;
   rteu_pkg::ms_type   est_base_ms = rteu_pkg::MAX_RETRY_RESET;
   rteu_pkg::ms_type   est_history [HIST_DEPTH] = '{default: '0};
   logic [19:0]        est_sum     = '0;

   rto_result_type     timeout_results_q [$];

   int                 fail_count  = 0;
   int                 tx_idle_pct = 33;
   int                 rx_idle_pct = 87;
   int                 hold_req    = 0;   // set by a test, taken by the receiver
   int                 hold_left   = 0;

   // Advance the mirror by one accepted item and return its result.
   function automatic rto_result_type step_rto_estimate(rto_request_type rq);
      rto_result_type res;
      int unsigned slot;
      logic [31:0] s8;
      logic [31:0] srtt32;
      logic [31:0] var32;
      logic [31:0] dev;
      logic [31:0] tmo;
      int unsigned shifts;
      logic [63:0] delay;
      if (rq.command == rteu_pkg::CMD_ACK) begin
         slot = rq.command_id % HIST_DEPTH;
         est_sum = est_sum - 20'(est_history[slot]) + 20'(rq.sample_ms);
         est_history[slot] = rq.sample_ms;
         // Karn: only samples of commands sent once (or zero) are timed
         if (rq.times_sent <= 1) begin
            s8 = 32'(rq.sample_ms) << 3;
            if (!est_seeded) begin
               srtt32     = s8;
               var32      = 32'(rq.sample_ms) << 2;
               est_seeded = 1'b1;
            end else begin
               srtt32 = 32'(est_srtt);
               var32  = 32'(est_rttvar);
               dev    = (srtt32 >= s8) ? srtt32 - s8 : s8 - srtt32;
               var32  = (3 * var32 + dev) >> 2;
               srtt32 = (7 * srtt32 + s8) >> 3;
            end
            est_srtt   = srtt32[RTT_W-1:0];
            est_rttvar = var32[RTT_W-1:0];
            tmo = (32'(est_srtt) + 4 * 32'(est_rttvar)) >> 3;
            // floor first, so a ceiling below the floor wins
            if (tmo < 32'(cfg_min_ms)) tmo = 32'(cfg_min_ms);
            if (tmo > 32'(cfg_max_ms)) tmo = 32'(cfg_max_ms);
            est_base_ms = tmo[MS_W-1:0];
         end
      end
      shifts = (rq.times_sent > 0) ? 32'(rq.times_sent) - 32'd1 : 32'd0;
      if (shifts > 32'(cfg_max_shifts)) shifts = 32'(cfg_max_shifts);
      delay = 64'(est_base_ms) << shifts;
      if (delay > 64'(cfg_max_ms)) delay = 64'(cfg_max_ms);
      res.timeout_ms = est_base_ms;
      res.delay_ms   = delay[MS_W-1:0];
      res.average_ms = MS_W'(est_sum / HIST_DEPTH);
      return res;
   endfunction

   // ------------------------------------------------------------------------
   // Result side: check each transfer against the oldest entry, then pick
   // tready for the next edge (long hold first, else random idling).
   // ------------------------------------------------------------------------
   task automatic check_timeout_result(logic [RSP_DATA_W-1:0] data);
      rto_result_type want;
      rto_result_type got;
      got.timeout_ms = data[MS_W-1:0];
      got.delay_ms   = data[2*MS_W-1:MS_W];
      got.average_ms = data[3*MS_W-1:2*MS_W];
      if (timeout_results_q.size() == 0) begin
         fail_count++;
         if (fail_count <= MAX_REPORTS)
            $display("%0t: result transfer with nothing pending, tdata %h", $time, data);
         return;
      end
      want = timeout_results_q.pop_front();
      if (got.timeout_ms !== want.timeout_ms || got.delay_ms !== want.delay_ms ||
          got.average_ms !== want.average_ms) begin
         fail_count++;
         if (fail_count <= MAX_REPORTS)
            $display("%0t: timeout exp %0d got %0d, delay exp %0d got %0d, avg exp %0d got %0d",
                     $time, want.timeout_ms, got.timeout_ms, want.delay_ms, got.delay_ms,
                     want.average_ms, got.average_ms);
      end
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         check_timeout_result(rsp_tdata);
      if (hold_req != 0) begin
         hold_left = hold_req;
         hold_req  = 0;
      end
      if (hold_left != 0) begin
         hold_left  = hold_left - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
      end
   end

   // ------------------------------------------------------------------------
   // Input side helpers; every task starts and ends on a rising-edge step
   // ------------------------------------------------------------------------
   task automatic send_request(rto_request_type rq);
      // optional idle gap; valid drops once and stays low for the gap
      if ($urandom_range(0, 99) < tx_idle_pct) begin
         req_tvalid <= 1'b0;
         do @(posedge clock); while ($urandom_range(0, 99) < tx_idle_pct);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= rq.command;
      req_tdata  <= {rq.times_sent, rq.command_id, rq.sample_ms};
      do @(posedge clock); while (!req_tready);
      // transfer taken at this edge
      timeout_results_q.push_back(step_rto_estimate(rq));
   endtask

   function automatic rto_request_type make_request(logic cmd, rteu_pkg::ms_type sample,
                                                    logic [ID_W-1:0] id,
                                                    logic [SENT_W-1:0] sent);
      rto_request_type rq;
      rq.command    = cmd;
      rq.sample_ms  = sample;
      rq.command_id = id;
      rq.times_sent = sent;
      return rq;
   endfunction

   // Mostly timed acks with plausible samples; some resends, queries and
   // full-range noise so every field bit toggles.
   function automatic rto_request_type random_request();
      rto_request_type rq;
      int unsigned     pick;
      pick = $urandom_range(0, 99);
      rq.command = (pick < 15) ? CMD_QUERY : rteu_pkg::CMD_ACK;
      pick = $urandom_range(0, 99);
      if (pick < 80)      rq.sample_ms = MS_W'($urandom_range(0, 3000));
      else if (pick < 90) rq.sample_ms = MS_W'($urandom_range(0, 200));
      else                rq.sample_ms = MS_W'($urandom_range(0, 65535));
      rq.command_id = ID_W'($urandom_range(0, 65535));
      pick = $urandom_range(0, 99);
      if (pick < 70)      rq.times_sent = SENT_W'($urandom_range(0, 1));
      else if (pick < 90) rq.times_sent = SENT_W'($urandom_range(2, 6));
      else                rq.times_sent = SENT_W'($urandom_range(0, 255));
      return rq;
   endfunction

   // Sender pause: nothing offered until every pending result is back.
   task automatic drain_results();
      req_tvalid <= 1'b0;
      while (timeout_results_q.size() != 0) @(posedge clock);
      repeat (PIPE_SETTLE) @(posedge clock);
   endtask

   task automatic write_reg(logic [CSR_INDEX_W-1:0] idx, logic [CSR_DATA_W-1:0] value);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      case (idx)
         rteu_pkg::CSR_MIN_RETRY:  cfg_min_ms     = value;
         rteu_pkg::CSR_MAX_RETRY:  cfg_max_ms     = value;
         rteu_pkg::CSR_MAX_SHIFTS: cfg_max_shifts = value[SHIFT_W-1:0];
         default: ;
      endcase
      @(posedge clock);
   endtask

   task automatic set_config(rteu_pkg::ms_type min_ms, rteu_pkg::ms_type max_ms,
                             logic [CSR_DATA_W-1:0] shift_word);
      drain_results();
      write_reg(rteu_pkg::CSR_MIN_RETRY, min_ms);
      write_reg(rteu_pkg::CSR_MAX_RETRY, max_ms);
      write_reg(rteu_pkg::CSR_MAX_SHIFTS, shift_word);
   endtask

   // ------------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------------

   // Queries before any sample: reset timeout, backoff capped at reset max.
   task automatic test_reset_queries();
      send_request(make_request(CMD_QUERY, 16'hFFFF, 16'hFFFF, 8'd0));
      send_request(make_request(CMD_QUERY, 16'h0000, 16'h0000, 8'd1));
      send_request(make_request(CMD_QUERY, 16'h1234, 16'h0007, 8'd3));
      send_request(make_request(CMD_QUERY, 16'h8000, 16'h8000, 8'd255));
   endtask

   // First sample seeds, later ones use the 1/8 and 1/4 gains; zero count
   // is timed like a single send; sample and id extremes.
   task automatic test_timed_samples();
      send_request(make_request(rteu_pkg::CMD_ACK, 16'd100,   16'd0,     8'd1));
      send_request(make_request(rteu_pkg::CMD_ACK, 16'd180,   16'd1,     8'd0));
      send_request(make_request(rteu_pkg::CMD_ACK, 16'd0,     16'd2,     8'd1));
      send_request(make_request(rteu_pkg::CMD_ACK, 16'hFFFF,  16'hFFFF,  8'd1));
      send_request(make_request(rteu_pkg::CMD_ACK, 16'h5555,  16'hAAAA,  8'd1));
   endtask

   // Resent command acked: history moves, estimate and base stay.
   task automatic test_resent_acks();
      send_request(make_request(rteu_pkg::CMD_ACK, 16'd900,  16'h8001, 8'd2));
      send_request(make_request(rteu_pkg::CMD_ACK, 16'hFFFF, 16'd16,   8'd255));
      send_request(make_request(CMD_QUERY,         16'd0,    16'd0,    8'd2));
   endtask

   task automatic test_register_cases();
      // floor above ceiling: ceiling wins
      set_config(16'd3000, 16'd1000, 16'd2);
      send_request(make_request(rteu_pkg::CMD_ACK, 16'd200, 16'd3, 8'd1));
      send_request(make_request(CMD_QUERY,         16'd0,   16'd0, 8'd4));
      // widest window, most shifts
      set_config(16'd0, 16'hFFFF, 16'd15);
      send_request(make_request(rteu_pkg::CMD_ACK, 16'd5000, 16'd4, 8'd1));
      send_request(make_request(CMD_QUERY,         16'd0,    16'd0, 8'd16));
      send_request(make_request(CMD_QUERY,         16'd0,    16'd0, 8'd255));
      // ceiling lowered afterwards: base kept until next timed ack
      drain_results();
      write_reg(rteu_pkg::CSR_MAX_RETRY, 16'd100);
      send_request(make_request(CMD_QUERY,         16'd0,   16'd0, 8'd1));
      send_request(make_request(rteu_pkg::CMD_ACK, 16'd300, 16'd5, 8'd3));
      send_request(make_request(rteu_pkg::CMD_ACK, 16'd40,  16'd6, 8'd1));
      // no backoff at all; upper data bits are noise for a 4-bit register
      set_config(16'd0, 16'hFFFF, 16'hFFF0);
      send_request(make_request(CMD_QUERY, 16'd0, 16'd0, 8'd200));
      // unused index must leave every register alone
      drain_results();
      write_reg(CSR_SPARE, 16'($urandom_range(0, 65535)));
      send_request(make_request(CMD_QUERY, 16'd0, 16'd0, 8'd2));
   endtask

   // Random traffic; idle pattern changes every two phases.
   task automatic test_random_traffic();
      for (int p = 0; p < RANDOM_PHASES; p++) begin
         case (p)
            0: set_config(rteu_pkg::MIN_RETRY_RESET, rteu_pkg::MAX_RETRY_RESET,
                          16'(rteu_pkg::MAX_SHIFTS_RESET));
            1: set_config(16'($urandom_range(0, 400)), 16'($urandom_range(500, 8000)),
                          16'($urandom_range(0, 65535)));
            2: set_config(16'd0, 16'hFFFF, 16'd15);
            3: set_config(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                          16'($urandom_range(0, 65535)));
            4: set_config(16'd1000, 16'd1500, 16'($urandom_range(0, 15)));
            default: set_config(16'd20, 16'd600, 16'($urandom_range(0, 15)));
         endcase
         case (p / 2)
            0: begin
               tx_idle_pct = 33;
               rx_idle_pct = 87;
            end
            1: begin
               tx_idle_pct = 87;
               rx_idle_pct = 33;
            end
            default: begin
               tx_idle_pct = 0;
               rx_idle_pct = 0;
            end
         endcase
         for (int n = 0; n < ITEMS_PER_PHASE; n++)
            send_request(random_request());
      end
   endtask

   // Receiver holds off while the sender keeps offering: pipe fills and
   // req_tready must drop, then everything drains in order.
   task automatic test_backpressure();
      set_config(16'd50, 16'd4000, 16'd4);
      tx_idle_pct = 0;
      rx_idle_pct = 0;
      hold_req    = LONG_HOLD;
      for (int n = 0; n < 40; n++)
         send_request(random_request());
      drain_results();
   endtask

   // ------------------------------------------------------------------------
   // Sequence
   // ------------------------------------------------------------------------
   initial begin
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_reset_queries();
      test_timed_samples();
      test_resent_acks();
      test_register_cases();
      test_random_traffic();
      test_backpressure();

      drain_results();
      if (fail_count == 0)
         $display("[retransmit_timeout_estimator_unit] OK");
      else
         $display("[retransmit_timeout_estimator_unit] ERROR");
      $finish;
   end

   // hang guard
   initial begin
      #(RUN_LIMIT);
      $display("[retransmit_timeout_estimator_unit] ERROR");
      $finish;
   end

endmodule
